@@ hdl/word_mix_content_hash_64_macros.svh @@
// ----------------------------------------------------------------------------
// Word mix content hash: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WORD_MIX_CONTENT_HASH_64_MACROS_SVH
`define WORD_MIX_CONTENT_HASH_64_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define WMCH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define WMCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wmch_pkg.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash: package
// Constants, controller states, datapath command and status types and the
// byte fold helper shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package wmch_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned IndexW = 29;
  localparam int unsigned MixShift = 29;

  localparam logic [WordW-1:0] GoldenStep = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixMult    = 64'hFF51_AFD7_ED55_8CCD;
  // FNV-64 prime is 2^40 + 0x1B3
  localparam int unsigned       FnvShift  = 40;
  localparam logic [WordW-1:0]  FnvLow    = 64'h0000_0000_0000_01B3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FOLD,
    ST_TAIL,
    ST_DELIVER
  } state_e;

  // Which 32x32 partial product the shared multiplier forms
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_sel_e;

  typedef struct packed {
    logic     load;     // capture the accepted beat
    logic     mul_en;   // form a partial product
    mul_sel_e mul_sel;
    logic     fold;     // finish the word mix and fold it into the hash
    logic     tail;     // fold one byte of a partial word
    logic     finish;   // move the hash to the output and clear the state
  } cmd_t;

  typedef struct packed {
    logic one_left;     // one tail byte remains
    logic last;         // the captured beat ends the message
  } status_t;

  // A byte count of 8 or more is a full word
  function automatic logic is_full(input logic [CountW-1:0] count);
    is_full = count[CountW-1];
  endfunction

  // One FNV-style step: (h ^ b) * prime, modulo 2^64
  function automatic logic [WordW-1:0] fnv_step(input logic [WordW-1:0] h,
                                                input logic [7:0]       b);
    logic [WordW-1:0] x;
    x = h ^ {{(WordW-8){1'b0}}, b};
    fnv_step = (x << FnvShift) + WordW'(x * FnvLow);
  endfunction

endpackage

@@ hdl/wmch_datapath.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash: datapath
// Holds the running hash, word index and golden-ratio multiple, and forms the
// 64-bit mixing product from three 32x32 partial products on one multiplier.
// ----------------------------------------------------------------------------
module wmch_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wmch_pkg::cmd_t                cmd_i,
  output wmch_pkg::status_t             status_o,
  input  logic [wmch_pkg::WordW-1:0]    data_word_i,
  input  logic [wmch_pkg::CountW-1:0]   byte_count_i,
  input  logic                          last_i,
  output logic [wmch_pkg::WordW-1:0]    hash_value_o
);

  logic [wmch_pkg::WordW-1:0]  word_q, word_d;
  logic [wmch_pkg::WordW-1:0]  prod_q, prod_d;
  logic [wmch_pkg::WordW-1:0]  hash_q, hash_d;
  logic [wmch_pkg::WordW-1:0]  golden_q, golden_d;
  logic [wmch_pkg::IndexW-1:0] index_q, index_d;
  logic [2:0]                  cnt_q, cnt_d;
  logic                        last_q, last_d;
  logic [wmch_pkg::WordW-1:0]  out_q, out_d;

  logic [wmch_pkg::HalfW-1:0]  mul_a, mul_b;
  logic [wmch_pkg::WordW-1:0]  mul_p;
  logic [wmch_pkg::WordW-1:0]  mixed;

  // Pick the operand halves for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      wmch_pkg::MUL_LL: begin
        mul_a = word_q[wmch_pkg::HalfW-1:0];
        mul_b = wmch_pkg::MixMult[wmch_pkg::HalfW-1:0];
      end
      wmch_pkg::MUL_HL: begin
        mul_a = word_q[wmch_pkg::WordW-1:wmch_pkg::HalfW];
        mul_b = wmch_pkg::MixMult[wmch_pkg::HalfW-1:0];
      end
      wmch_pkg::MUL_LH: begin
        mul_a = word_q[wmch_pkg::HalfW-1:0];
        mul_b = wmch_pkg::MixMult[wmch_pkg::WordW-1:wmch_pkg::HalfW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{wmch_pkg::HalfW{1'b0}}, mul_a} * {{wmch_pkg::HalfW{1'b0}}, mul_b};
  assign mixed = prod_q ^ (prod_q >> wmch_pkg::MixShift);

  // Next values of the datapath registers
  always_comb begin
    word_d   = word_q;
    prod_d   = prod_q;
    hash_d   = hash_q;
    golden_d = golden_q;
    index_d  = index_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    out_d    = out_q;

    // capture a beat; a full word is pre-XORed with index * golden step
    if (cmd_i.load) begin
      word_d = wmch_pkg::is_full(byte_count_i) ? (data_word_i ^ golden_q) : data_word_i;
      cnt_d  = byte_count_i[2:0];
      last_d = last_i;
    end

    // accumulate partial products: low x low, then the two cross terms
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_sel == wmch_pkg::MUL_LL) begin
        prod_d = mul_p;
      end else begin
        prod_d = prod_q + {mul_p[wmch_pkg::HalfW-1:0], {wmch_pkg::HalfW{1'b0}}};
      end
    end

    // fold the mixed word and advance the index; the golden multiple
    // returns to zero where the index wraps
    if (cmd_i.fold) begin
      hash_d   = hash_q ^ mixed;
      index_d  = index_q + 1'b1;
      golden_d = (&index_q) ? '0 : golden_q + wmch_pkg::GoldenStep;
    end

    // fold one tail byte, lowest first
    if (cmd_i.tail) begin
      hash_d = wmch_pkg::fnv_step(hash_q, word_q[7:0]);
      word_d = word_q >> 8;
      cnt_d  = cnt_q - 1'b1;
    end

    // hand the hash to the output register and clear the message state
    if (cmd_i.finish) begin
      out_d    = hash_q;
      hash_d   = '0;
      index_d  = '0;
      golden_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      golden_q <= '0;
      index_q  <= '0;
    end else begin
      hash_q   <= hash_d;
      golden_q <= golden_d;
      index_q  <= index_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign status_o.one_left = (cnt_q == 3'd1);
  assign status_o.last     = last_q;
  assign hash_value_o      = out_q;

endmodule

@@ hdl/wmch_ctrl.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash: controller
// Sequences the word mix and the tail byte fold, drives the input stall and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`include "word_mix_content_hash_64_macros.svh"

module wmch_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wmch_pkg::CountW-1:0]   byte_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wmch_pkg::cmd_t                cmd_o,
  input  wmch_pkg::status_t             status_i
);

  wmch_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             accept;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign accept    = (state_q == wmch_pkg::ST_IDLE) && in_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmch_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority if (wmch_pkg::is_full(byte_count_i)) begin
            state_d = wmch_pkg::ST_MUL0;
          end else if (byte_count_i[2:0] == 3'd0) begin
            state_d = wmch_pkg::ST_DELIVER;
          end else begin
            state_d = wmch_pkg::ST_TAIL;
          end
        end
      end
      wmch_pkg::ST_MUL0: state_d = wmch_pkg::ST_MUL1;
      wmch_pkg::ST_MUL1: state_d = wmch_pkg::ST_MUL2;
      wmch_pkg::ST_MUL2: state_d = wmch_pkg::ST_FOLD;
      wmch_pkg::ST_FOLD: begin
        state_d = status_i.last ? wmch_pkg::ST_DELIVER : wmch_pkg::ST_IDLE;
      end
      wmch_pkg::ST_TAIL: begin
        if (status_i.one_left) begin
          state_d = wmch_pkg::ST_DELIVER;
        end
      end
      wmch_pkg::ST_DELIVER: begin
        if (slot_free) begin
          state_d = wmch_pkg::ST_IDLE;
        end
      end
      default: state_d = wmch_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = wmch_pkg::MUL_LL;
    cmd_o.load    = accept;
    unique case (state_q)
      wmch_pkg::ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = wmch_pkg::MUL_LL;
      end
      wmch_pkg::ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = wmch_pkg::MUL_HL;
      end
      wmch_pkg::ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = wmch_pkg::MUL_LH;
      end
      wmch_pkg::ST_FOLD:    cmd_o.fold   = 1'b1;
      wmch_pkg::ST_TAIL:    cmd_o.tail   = 1'b1;
      wmch_pkg::ST_DELIVER: cmd_o.finish = slot_free;
      default: ;
    endcase
  end

  // Hold the result until the beat is taken; reload when the slot frees
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmch_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != wmch_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // A waiting result is never overwritten
  `WMCH_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, cmd_o.finish,
                   !out_valid_q || !out_stall_i, "result overwritten while stalled")
  // The partial products always run to the fold
  `WMCH_ASSERT_NEXT(a_mul_to_fold, clk_i, rst_ni, state_q == wmch_pkg::ST_MUL2,
                    state_q == wmch_pkg::ST_FOLD, "mix sequence broken")
  // A new result appears only from the deliver state
  `WMCH_ASSERT_NOW(a_valid_source, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q) == wmch_pkg::ST_DELIVER, "result without deliver")
  // A nonempty partial word always enters the tail fold
  `WMCH_ASSERT_NEXT(a_tail_entry, clk_i, rst_ni,
                    accept && !wmch_pkg::is_full(byte_count_i) && (byte_count_i != '0),
                    state_q == wmch_pkg::ST_TAIL, "partial word skipped tail fold")

endmodule

@@ hdl/word_mix_content_hash_64.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash, 64-bit
// Hashes a byte message streamed as little-endian 64-bit words: full words
// are mixed and XORed into the hash, a final partial word is folded byte by
// byte, and the hash is delivered on the message's last beat.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  data_word_i, byte_count_i, last_i
//   out      source     out_valid_o/out_stall_i hash_value_o
//
// A full word runs through the beat, three partial products on the shared
// 32x32 multiplier, then the fold; a last full word adds a delivery step.
// A partial word is folded one byte per step, lowest first, then delivered.
// One beat is worked on at a time; the input stalls until it is done.
// A finished hash waits in the output register; delivery of the next one
// holds while that register is full and stalled.
// Reset clears the hash, the word index and the output valid flag.
// ----------------------------------------------------------------------------
module word_mix_content_hash_64 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wmch_pkg::WordW-1:0]    data_word_i,
  input  logic [wmch_pkg::CountW-1:0]   byte_count_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wmch_pkg::WordW-1:0]    hash_value_o
);

  wmch_pkg::cmd_t    cmd;
  wmch_pkg::status_t status;

  // Sequence the work
  wmch_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_count_i (byte_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // Compute the hash
  wmch_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .hash_value_o (hash_value_o)
  );

endmodule

@@ verif/wmch_hash_checker.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash: stream checker
// Watches the input and output channels of the hash block. It keeps its own
// copy of the running hash and the word index, works out the hash that each
// accepted message should produce, and compares every delivered hash with the
// oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wmch_hash_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [wmch_pkg::WordW-1:0]  data_word_i,
  input  logic [wmch_pkg::CountW-1:0] byte_count_i,
  input  logic                        last_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [wmch_pkg::WordW-1:0]  hash_value_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef logic [wmch_pkg::WordW-1:0]  word_t;
  typedef logic [wmch_pkg::IndexW-1:0] index_t;

  localparam word_t       PHI_STEP  = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t       MIX_MUL   = 64'hFF51_AFD7_ED55_8CCD;
  localparam word_t       FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam int unsigned MIX_SHR   = 29;
  localparam int unsigned FULL_BYTES = 8;

  word_t  run_hash;
  index_t word_idx;
  word_t  expected_hashes[$];

  // Spread the word by its index, multiply, then fold the high bits down
  function automatic word_t mix_full_word(input word_t w, input index_t idx);
    word_t spread;
    word_t prod;
    spread = word_t'(idx) * PHI_STEP;
    prod   = (w ^ spread) * MIX_MUL;
    return prod ^ (prod >> MIX_SHR);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    word_t h;
    word_t want;
    logic  msg_done;
    if (!rst_ni) begin
      run_hash = '0;
      word_idx = '0;
      expected_hashes.delete();
    end else begin
      // Predict the hash for each accepted input beat
      if (in_valid_i && !in_stall_i) begin
        h = run_hash;
        if (byte_count_i >= FULL_BYTES) begin
          h        = h ^ mix_full_word(data_word_i, word_idx);
          word_idx = word_idx + 1'b1;
          msg_done = last_i;
        end else begin
          for (int k = 0; k < byte_count_i; k++) begin
            h = (h ^ {56'd0, data_word_i[8*k +: 8]}) * FNV_PRIME;
          end
          msg_done = 1'b1;
        end
        if (msg_done) begin
          expected_hashes.push_back(h);
          run_hash = '0;
          word_idx = '0;
        end else begin
          run_hash = h;
        end
      end

      // Compare each delivered beat with the oldest expected hash
      if (out_valid_i && !out_stall_i) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: no hash expected, actual %h", hash_value_i);
          fail_count_o++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value_i !== want) begin
            $error("hash_value: expected %h, actual %h", want, hash_value_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_hashes.size();
  end

endmodule

@@ verif/tb_word_mix_content_hash_64.sv @@
// ----------------------------------------------------------------------------
// Word mix content hash: testbench top
// Drives byte messages into the hash block: a directed set of edge cases,
// then random messages of full words with optional partial tails. Both
// channels idle at random, the output holds off once for a long stretch, and
// the sender once drains all results. A checker module predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_word_mix_content_hash_64;

  typedef logic [wmch_pkg::WordW-1:0]  word_t;
  typedef logic [wmch_pkg::CountW-1:0] count_t;

  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 600000;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid;
  logic   in_stall;
  word_t  data_word;
  count_t byte_count;
  logic   msg_last;
  logic   out_valid;
  logic   out_stall;
  word_t  hash_value;

  int fail_count;
  int pending_hashes;
  int beats_sent;
  int cycle_count;
  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold;

  word_mix_content_hash_64 DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_word_i  (data_word),
    .byte_count_i (byte_count),
    .last_i       (msg_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hash_value_o (hash_value)
  );

  wmch_hash_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_word_i  (data_word),
    .byte_count_i (byte_count),
    .last_i       (msg_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .hash_value_i (hash_value),
    .fail_count_o (fail_count),
    .pending_o    (pending_hashes)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(input word_t w, input count_t n, input logic l);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    data_word  <= w;
    byte_count <= n;
    msg_last   <= l;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Full words, some with oversized counts, then an optional partial tail
  task automatic send_message(input int n_words, input bit with_tail,
                              input count_t tail_count);
    count_t cnt;
    for (int i = 0; i < n_words; i++) begin
      cnt = ($urandom_range(0, 9) == 0) ? count_t'($urandom_range(9, 15)) : count_t'(8);
      send_beat(rand_word(), cnt, !with_tail && (i == n_words - 1));
    end
    if (with_tail) begin
      send_beat(rand_word(), tail_count, 1'($urandom_range(0, 1)));
    end
  endtask

  // Output side: random stall runs, plus one long hold-off on request
  initial begin : sink
    int stall_run;
    stall_run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if (sink_idle_en && $urandom_range(0, 99) < 30) stall_run = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int msg;
    int n_words;
    bit with_tail;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    data_word    = '0;
    byte_count   = '0;
    msg_last     = 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    long_hold    = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty message, with last low: a short count always ends the message
    send_beat(64'hA5A5_5A5A_DEAD_BEEF, 4'd0, 1'b0);
    // Single full words at the data extremes
    send_beat('0, 4'd8, 1'b1);
    send_beat('1, 4'd8, 1'b1);
    // Every partial length, with random data in the unused bytes
    for (int n = 1; n < 8; n++) begin
      send_beat({$urandom, $urandom}, count_t'(n), n[0]);
    end
    // Two words, then a seven-byte tail with last low
    send_beat(rand_word(), 4'd8, 1'b0);
    send_beat(rand_word(), 4'd8, 1'b0);
    send_beat('1, 4'd7, 1'b0);
    // Oversized counts act as full words
    for (int n = 9; n < 16; n++) begin
      send_beat({$urandom, $urandom}, count_t'(n), n == 15);
    end
    // Word followed by an empty tail
    send_beat(rand_word(), 4'd8, 1'b0);
    send_beat(rand_word(), 4'd0, 1'b1);

    // Random messages, mostly short
    msg = 0;
    while (beats_sent < RANDOM_ITEMS + 22) begin
      if (msg % 40 == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (msg == 25) begin
        src_idle_en = 1'b0;
        long_hold   = 1'b1;
      end
      // Go quiet until every expected hash has come out
      if (msg == 70) begin
        in_valid <= 1'b0;
        while (pending_hashes != 0) @(negedge clk_i);
      end
      n_words   = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4)
                                                : $urandom_range(5, 24);
      with_tail = (n_words == 0) || ($urandom_range(0, 1) == 1);
      send_message(n_words, with_tail, count_t'($urandom_range(0, 7)));
      msg++;
    end
    in_valid <= 1'b0;

    // Drain outstanding hashes, then let the block settle
    while (pending_hashes != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
